[rtl/cckb_pkg.sv]
// Shared types, constants and helper functions of the colour-keyed sprite blitter.
`timescale 1ns / 1ps
package cckb_pkg;

  localparam int MAX_SURFACE_SIDE = 4096;
  localparam int SPRITE_SIDE_LIMIT = 4096;
  localparam int SIDE_W = $clog2(MAX_SURFACE_SIDE) + 1;
  localparam int COORD_W = $clog2(MAX_SURFACE_SIDE);
  localparam int COUNT_W = 12;
  localparam int PITCH_W = 16;
  localparam int PROD_W = COORD_W + PITCH_W;
  localparam int OFFSET_W = 28;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    REG_SURFACE_WIDTH  = 3'd0,
    REG_SURFACE_HEIGHT = 3'd1,
    REG_ROW_PITCH      = 3'd2,
    REG_DEST_X         = 3'd3,
    REG_DEST_Y         = 3'd4,
    REG_SPRITE_WIDTH   = 3'd5,
    REG_SPRITE_HEIGHT  = 3'd6,
    REG_COLOR_KEY      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic        use_key;
    logic        restart;
  } in_word_t;

  typedef struct packed {
    logic                write_enable;
    logic [OFFSET_W-1:0] byte_offset;
    logic [31:0]         write_data;
    logic                sprite_done;
  } out_word_t;

  typedef struct packed {
    logic [12:0]        surface_width;
    logic [12:0]        surface_height;
    logic [PITCH_W-1:0] row_pitch;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic [12:0]        sprite_width;
    logic [12:0]        sprite_height;
    logic [31:0]        color_key;
  } cfg_t;

  // Classified pixel handed from the front part to the back part.
  typedef struct packed {
    logic               write_enable;
    logic               sprite_done;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [31:0]        pixel;
  } cls_word_t;

  function automatic logic [SIDE_W-1:0] clamp_surface_side(input logic [12:0] v);
    if (int'(v) > MAX_SURFACE_SIDE) return SIDE_W'(MAX_SURFACE_SIDE);
    return SIDE_W'(v);
  endfunction

  // Sprite side clamped to 1..4096, returned minus one.
  function automatic logic [COUNT_W-1:0] sprite_last(input logic [12:0] v);
    if (v == 13'd0) return '0;
    if (int'(v) > SPRITE_SIDE_LIMIT) return COUNT_W'(SPRITE_SIDE_LIMIT - 1);
    return COUNT_W'(v - 13'd1);
  endfunction

endpackage

[rtl/cckb_front.sv]
// Front part: sprite position counters, clipping and colour-key test.
`timescale 1ns / 1ps
module cckb_front
  import cckb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      accept,
  input  in_word_t  in_word,
  output cls_word_t cls_word
);

  logic [COUNT_W-1:0] col_r, col_nxt;
  logic [COUNT_W-1:0] row_r, row_nxt;
  logic [COUNT_W-1:0] col_cur, row_cur;
  logic signed [16:0] x, y;
  logic [SIDE_W-1:0]  fw, fh;
  logic               x_ok, y_ok, on_surface, keyed, last_col, last_row;

  always_comb begin
    col_cur    = in_word.restart ? '0 : col_r;
    row_cur    = in_word.restart ? '0 : row_r;
    x          = 17'(cfg.dest_x) + $signed({5'b0, col_cur});
    y          = 17'(cfg.dest_y) + $signed({5'b0, row_cur});
    fw         = clamp_surface_side(cfg.surface_width);
    fh         = clamp_surface_side(cfg.surface_height);
    x_ok       = !x[16] && ({1'b0, x[15:0]} < 17'(fw));
    y_ok       = !y[16] && ({1'b0, y[15:0]} < 17'(fh));
    on_surface = x_ok && y_ok;
    keyed      = in_word.use_key && (in_word.pixel_value == cfg.color_key);
    last_col   = col_cur == sprite_last(cfg.sprite_width);
    last_row   = row_cur == sprite_last(cfg.sprite_height);

    cls_word.write_enable = on_surface && !keyed;
    cls_word.sprite_done  = last_col && last_row;
    // Zero the coordinates of a clipped pixel so its offset comes out as zero.
    cls_word.x            = on_surface ? x[COORD_W-1:0] : '0;
    cls_word.y            = on_surface ? y[COORD_W-1:0] : '0;
    cls_word.pixel        = in_word.pixel_value;

    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_cur + 1'b1;
    end else begin
      col_nxt = col_cur + 1'b1;
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  a_wrap_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cls_word.sprite_done |=> col_r == '0 && row_r == '0)
    else $error("counters did not wrap after the last pixel");

  a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !on_surface |-> !cls_word.write_enable && cls_word.x == '0 && cls_word.y == '0)
    else $error("clipped pixel carries a position");

endmodule

[rtl/cckb_queue.sv]
// Short register queue between the front and back parts.
`timescale 1ns / 1ps
module cckb_queue
  import cckb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_word_t push_word,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output cls_word_t pop_word
);

  cls_word_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign full      = count_r == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign pop_word  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from an empty queue");

endmodule

[rtl/cckb_back.sv]
// Back part: byte offset multiply-add and the output register.
`timescale 1ns / 1ps
module cckb_back
  import cckb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic [PITCH_W-1:0] row_pitch,
  input  logic         q_not_empty,
  input  cls_word_t    q_word,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output out_word_t    out_data
);

  logic                s1_valid_r, s1_valid_nxt;
  logic [PROD_W-1:0]   s1_prod_r;
  logic [COORD_W-1:0]  s1_x_r;
  logic                s1_we_r, s1_done_r;
  logic [31:0]         s1_pixel_r;
  logic                out_valid_r, advance;
  out_word_t           out_data_r;
  logic [PROD_W:0]     sum;

  // Advance whenever the output register is free or being taken.
  assign advance = !out_valid_r || !out_stall;
  assign q_pop   = q_not_empty && (advance || !s1_valid_r);
  assign sum     = {1'b0, s1_prod_r} + (PROD_W + 1)'({s1_x_r, 2'b00});

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (advance || !s1_valid_r) s1_valid_nxt = q_pop;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_prod_r  <= PROD_W'(q_word.y * row_pitch);
      s1_x_r     <= q_word.x;
      s1_we_r    <= q_word.write_enable;
      s1_done_r  <= q_word.sprite_done;
      s1_pixel_r <= q_word.pixel;
    end
    if (advance && s1_valid_r) begin
      out_data_r.write_enable <= s1_we_r;
      out_data_r.byte_offset  <= OFFSET_W'(sum);
      out_data_r.write_data   <= s1_pixel_r;
      out_data_r.sprite_done  <= s1_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (advance) out_valid_r <= s1_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("multiply stage lost a word while the output stalled");

endmodule

[rtl/clipped_color_key_blitter.sv]
// Top level of the clipped, colour-keyed sprite blitter.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall / in_data): one sprite pixel per word in
//   raster order, with use_key and restart. restart marks a sprite's first pixel.
//   Output channel (out_valid / out_stall / out_data): one word per pixel with
//   write enable, byte offset (row * pitch + column * 4), pixel and sprite_done.
//   Configuration (cfg_we / cfg_index / cfg_data): surface size, row pitch,
//   destination, sprite size and colour key; write only while the block is idle.
// Throughput: one pixel per clock while the receiver does not stall.
// Path: an accepted input word passes through the four-entry queue, the row * pitch
//   multiply register and the output register before it is valid at the output.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
//   position counters and empties the queue and output register.
// When the receiver stalls, the output word holds; the multiply stage and
//   queue fill up, and in_stall rises once the queue is full.
module clipped_color_key_blitter
  import cckb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  reg_idx_t  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t      cfg_r;
  logic      accept, q_full, q_pop, q_not_empty;
  cls_word_t cls_word, q_word;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.surface_width  <= 13'd640;
      cfg_r.surface_height <= 13'd480;
      cfg_r.row_pitch      <= 16'd2560;
      cfg_r.dest_x         <= '0;
      cfg_r.dest_y         <= '0;
      cfg_r.sprite_width   <= 13'd1;
      cfg_r.sprite_height  <= 13'd1;
      cfg_r.color_key      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SURFACE_WIDTH:  cfg_r.surface_width  <= cfg_data[12:0];
        REG_SURFACE_HEIGHT: cfg_r.surface_height <= cfg_data[12:0];
        REG_ROW_PITCH:      cfg_r.row_pitch      <= cfg_data[15:0];
        REG_DEST_X:         cfg_r.dest_x         <= cfg_data[15:0];
        REG_DEST_Y:         cfg_r.dest_y         <= cfg_data[15:0];
        REG_SPRITE_WIDTH:   cfg_r.sprite_width   <= cfg_data[12:0];
        REG_SPRITE_HEIGHT:  cfg_r.sprite_height  <= cfg_data[12:0];
        REG_COLOR_KEY:      cfg_r.color_key      <= cfg_data;
        default: ;
      endcase
    end
  end

  cckb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (accept),
    .in_word  (in_data),
    .cls_word (cls_word)
  );

  cckb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_word (cls_word),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_word  (q_word)
  );

  cckb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .row_pitch   (cfg_r.row_pitch),
    .q_not_empty (q_not_empty),
    .q_word      (q_word),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
